// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the encoder outlier filter.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/edof_pkg.sv =====
// Types and constants of the encoder delta outlier filter.
// No dependencies; used by every module of the block.
`default_nettype none

package edof_pkg;

  // re-reads consulted after a fresh read falls outside the gate (0..2)
  localparam int unsigned RETRY_READS = 2;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned TARGET_W = 16;
  localparam int unsigned GATE_W   = 16;
  localparam int unsigned STREAK_W = 8;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_GATE     = 2'd0;
  localparam logic [1:0] REG_GATE_GAIN    = 2'd1;
  localparam logic [1:0] REG_STREAK_LIMIT = 2'd2;

  localparam logic [15:0] MIN_GATE_RST     = 16'd640;
  localparam logic [15:0] GATE_GAIN_RST    = 16'd13107;
  localparam logic [7:0]  STREAK_LIMIT_RST = 8'd3;

  typedef enum logic [1:0] {
    VERDICT_FRESH  = 2'd0,
    VERDICT_REREAD = 2'd1,
    VERDICT_HELD   = 2'd2,
    VERDICT_FORCED = 2'd3
  } verdict_t;

  // per-transaction control computed from the speed targets
  typedef struct packed {
    logic              driving;
    logic [GATE_W-1:0] gate;
  } gate_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/edof_gate.sv =====
// Gate width and driving flag from the two speed targets.
// Depends on edof_pkg.
`default_nettype none

module edof_gate (
  input  wire logic signed [15:0] target_right,
  input  wire logic signed [15:0] target_left,
  input  wire logic        [15:0] min_gate,
  input  wire logic        [15:0] gate_gain,
  output edof_pkg::gate_ctl_t     ctl
);

  logic signed [16:0] tr_ext;
  logic signed [16:0] tl_ext;
  logic        [16:0] mag_r;
  logic        [16:0] mag_l;
  logic        [16:0] mag_max;
  logic        [32:0] prod;
  logic        [15:0] scaled;

  assign tr_ext = {target_right[15], target_right};
  assign tl_ext = {target_left[15], target_left};
  assign mag_r  = tr_ext[16] ? 17'(-tr_ext) : 17'(tr_ext);
  assign mag_l  = tl_ext[16] ? 17'(-tl_ext) : 17'(tl_ext);
  assign mag_max = (mag_r > mag_l) ? mag_r : mag_l;

  // gain is Q0.16; |d|*2^16 <= gain*m  <=>  |d| <= floor(gain*m / 2^16)
  assign prod   = 33'(gate_gain) * 33'(mag_max);
  assign scaled = prod[31:16];

  assign ctl.driving = (|target_right) || (|target_left);
  assign ctl.gate    = (scaled > min_gate) ? scaled : min_gate;

endmodule

`default_nettype wire

// ===== rtl/edof_wheel.sv =====
// One wheel: gate test of fresh read and re-reads, baseline and reject streak.
// Depends on edof_pkg.
`default_nettype none

module edof_wheel (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                upd,
  input  wire edof_pkg::gate_ctl_t ctl,
  input  wire logic         [7:0]  streak_limit,
  input  wire logic signed  [31:0] fresh,
  input  wire logic signed  [31:0] reread1,
  input  wire logic signed  [31:0] reread2,
  output logic signed       [31:0] pos,
  output edof_pkg::verdict_t       verdict
);

  logic signed [31:0] baseline;
  logic        [7:0]  streak;
  logic        [7:0]  streak_next;
  logic        [7:0]  streak_inc;
  logic               ok0;
  logic               ok1;
  logic               ok2;
  logic               forced;

  function automatic logic in_gate(input logic signed [31:0] rd,
                                   input logic signed [31:0] base,
                                   input logic [15:0] gate);
    logic signed [32:0] d;
    logic        [32:0] mag;
    d   = 33'({rd[31], rd}) - 33'({base[31], base});
    mag = d[32] ? 33'(-d) : 33'(d);
    return mag <= {17'd0, gate};
  endfunction

  assign ok0 = in_gate(fresh, baseline, ctl.gate);
  assign ok1 = (edof_pkg::RETRY_READS >= 1) && in_gate(reread1, baseline, ctl.gate);
  assign ok2 = (edof_pkg::RETRY_READS >= 2) && in_gate(reread2, baseline, ctl.gate);

  // streak saturates at all ones
  assign streak_inc = (&streak) ? streak : streak + 8'd1;
  assign forced     = streak_inc >= streak_limit;

  always_comb begin
    if (!ctl.driving || ok0) begin
      pos         = fresh;
      verdict     = edof_pkg::VERDICT_FRESH;
      streak_next = '0;
    end else if (forced) begin
      pos         = fresh;
      verdict     = edof_pkg::VERDICT_FORCED;
      streak_next = '0;
    end else if (ok1) begin
      pos         = reread1;
      verdict     = edof_pkg::VERDICT_REREAD;
      streak_next = streak_inc;
    end else if (ok2) begin
      pos         = reread2;
      verdict     = edof_pkg::VERDICT_REREAD;
      streak_next = streak_inc;
    end else begin
      pos         = baseline;
      verdict     = edof_pkg::VERDICT_HELD;
      streak_next = streak_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
      streak   <= '0;
    end else if (upd) begin
      baseline <= pos;
      streak   <= streak_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/encoder_delta_outlier_filter.sv =====
// Encoder delta outlier filter, top level: handshake stages, APB registers.
// Path: input register s1, then result register; baselines update as s1 advances.
// Throughput: one transaction per cycle while out_stall does not hold the result.
// Reset (rst, synchronous): both stages empty, baselines and streaks zero,
//   registers min_gate 640, gate_gain 13107, streak_limit 3.
// Depends on edof_pkg, edof_gate, edof_wheel, assert_macros.svh.
`default_nettype none

module encoder_delta_outlier_filter (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [3:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] target_right,
  input  wire logic signed [15:0] target_left,
  input  wire logic signed [31:0] fresh_right,
  input  wire logic signed [31:0] reread1_right,
  input  wire logic signed [31:0] reread2_right,
  input  wire logic signed [31:0] fresh_left,
  input  wire logic signed [31:0] reread1_left,
  input  wire logic signed [31:0] reread2_left,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] pos_right,
  output logic signed      [31:0] pos_left,
  output logic             [1:0]  verdict_right,
  output logic             [1:0]  verdict_left,
  output logic                    driving
);

  // ---------------- configuration registers ----------------
  logic [15:0] min_gate;
  logic [15:0] gate_gain;
  logic [7:0]  streak_limit;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gate     <= edof_pkg::MIN_GATE_RST;
      gate_gain    <= edof_pkg::GATE_GAIN_RST;
      streak_limit <= edof_pkg::STREAK_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        edof_pkg::REG_MIN_GATE:     min_gate     <= pwdata[15:0];
        edof_pkg::REG_GATE_GAIN:    gate_gain    <= pwdata[15:0];
        edof_pkg::REG_STREAK_LIMIT: streak_limit <= pwdata[7:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      edof_pkg::REG_MIN_GATE:     prdata = {16'd0, min_gate};
      edof_pkg::REG_GATE_GAIN:    prdata = {16'd0, gate_gain};
      edof_pkg::REG_STREAK_LIMIT: prdata = {24'd0, streak_limit};
      default:                    prdata = '0;
    endcase
  end

  // ---------------- handshake control ----------------
  // s1 holds an accepted transaction; it moves to the result register when
  // that register is empty or being drained this cycle. Baselines update on
  // the same edge, so the next transaction in s1 sees them immediately.
  logic s1_valid;
  logic accept;
  logic advance;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= accept || (s1_valid && !advance);
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  // ---------------- input stage ----------------
  // Gate product is formed ahead of s1 so the loop stage is compare/select only.
  edof_pkg::gate_ctl_t in_ctl;
  edof_pkg::gate_ctl_t s1_ctl;
  logic signed [31:0] s1_fresh_r;
  logic signed [31:0] s1_rr1_r;
  logic signed [31:0] s1_rr2_r;
  logic signed [31:0] s1_fresh_l;
  logic signed [31:0] s1_rr1_l;
  logic signed [31:0] s1_rr2_l;

  edof_gate u_gate (
    .target_right (target_right),
    .target_left  (target_left),
    .min_gate     (min_gate),
    .gate_gain    (gate_gain),
    .ctl          (in_ctl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl     <= in_ctl;
      s1_fresh_r <= fresh_right;
      s1_rr1_r   <= reread1_right;
      s1_rr2_r   <= reread2_right;
      s1_fresh_l <= fresh_left;
      s1_rr1_l   <= reread1_left;
      s1_rr2_l   <= reread2_left;
    end
  end

  // ---------------- per-wheel filters ----------------
  logic signed [31:0]  pos_r_next;
  logic signed [31:0]  pos_l_next;
  edof_pkg::verdict_t  verdict_r_next;
  edof_pkg::verdict_t  verdict_l_next;

  edof_wheel u_wheel_right (
    .clk          (clk),
    .rst          (rst),
    .upd          (advance),
    .ctl          (s1_ctl),
    .streak_limit (streak_limit),
    .fresh        (s1_fresh_r),
    .reread1      (s1_rr1_r),
    .reread2      (s1_rr2_r),
    .pos          (pos_r_next),
    .verdict      (verdict_r_next)
  );

  edof_wheel u_wheel_left (
    .clk          (clk),
    .rst          (rst),
    .upd          (advance),
    .ctl          (s1_ctl),
    .streak_limit (streak_limit),
    .fresh        (s1_fresh_l),
    .reread1      (s1_rr1_l),
    .reread2      (s1_rr2_l),
    .pos          (pos_l_next),
    .verdict      (verdict_l_next)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (advance) begin
      pos_right     <= pos_r_next;
      pos_left      <= pos_l_next;
      verdict_right <= 2'(verdict_r_next);
      verdict_left  <= 2'(verdict_l_next);
      driving       <= s1_ctl.driving;
    end
  end

  // ---------------- assertions ----------------
  logic out_free;
  logic both_fresh;

  assign out_free   = !out_valid || !out_stall;
  assign both_fresh = (verdict_right == 2'(edof_pkg::VERDICT_FRESH)) &&
                      (verdict_left == 2'(edof_pkg::VERDICT_FRESH));

`include "assert_macros.svh"

  `ASSERT_CLK(a_stall_needs_s1, in_stall |-> s1_valid, "input stalled with empty s1")
  `ASSERT_CLK(a_free_out_no_stall, out_free |-> !in_stall, "stall with result reg free")
  `ASSERT_CLK(a_idle_fresh, (out_valid && !driving) |-> both_fresh, "idle with non-fresh verdict")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> (!s1_valid && !out_valid), "stages not empty after reset")

endmodule

`default_nettype wire

// ===== verif/encoder_delta_outlier_filter_tb.sv =====
// Self-checking testbench for encoder_delta_outlier_filter: a position tracker class
// predicts each result, and plain tasks drive the transaction channels and APB writes.
// Depends on edof_pkg and the RTL top level only.
`timescale 1ns / 100ps

module encoder_delta_outlier_filter_tb;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN = 10;
  localparam logic signed [15:0] TGT_EDGES [4] = '{16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff};

  // one control tick as presented on the input channel
  typedef struct {
    logic signed [15:0] tgt_r;
    logic signed [15:0] tgt_l;
    logic signed [31:0] fresh_r;
    logic signed [31:0] rr1_r;
    logic signed [31:0] rr2_r;
    logic signed [31:0] fresh_l;
    logic signed [31:0] rr1_l;
    logic signed [31:0] rr2_l;
  } tick_t;

  // one filtered result
  typedef struct {
    logic signed [31:0] pos_r;
    logic signed [31:0] pos_l;
    edof_pkg::verdict_t verdict_r;
    edof_pkg::verdict_t verdict_l;
    logic               driving;
  } fix_t;

  // Tracks baselines and reject streaks per wheel (index 0 right, 1 left), queues the
  // filtered position each accepted tick should produce and matches results against it.
  class position_tracker;
    logic [15:0]        min_gate;
    logic [15:0]        gate_gain;
    logic [7:0]         streak_limit;
    logic signed [31:0] pos_base [2];
    logic [7:0]         reject_run [2];
    fix_t               fix_q [$];
    int unsigned        mismatches;

    function new();
      min_gate      = edof_pkg::MIN_GATE_RST;
      gate_gain     = edof_pkg::GATE_GAIN_RST;
      streak_limit  = edof_pkg::STREAK_LIMIT_RST;
      pos_base[0]   = '0;
      pos_base[1]   = '0;
      reject_run[0] = '0;
      reject_run[1] = '0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        edof_pkg::REG_MIN_GATE:     min_gate = val[15:0];
        edof_pkg::REG_GATE_GAIN:    gate_gain = val[15:0];
        edof_pkg::REG_STREAK_LIMIT: streak_limit = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return fix_q.size();
    endfunction

    // larger of the two target magnitudes, 0..32768
    function int unsigned peak(logic signed [15:0] tr, logic signed [15:0] tl);
      int ar;
      int al;
      ar = tr;
      al = tl;
      if (ar < 0) ar = -ar;
      if (al < 0) al = -al;
      return (ar > al) ? ar : al;
    endfunction

    // gate width in position units, rounded down; only used to aim stimulus
    function longint span(logic signed [15:0] tr, logic signed [15:0] tl);
      longint unsigned prod;
      prod = longint'(gate_gain) * longint'(peak(tr, tl));
      return ((prod >> 16) > min_gate) ? longint'(prod >> 16) : longint'(min_gate);
    endfunction

    // exact compare: |d| <= min_gate or |d| * 2^16 <= gain * peak
    function bit in_gate(logic signed [31:0] rd, logic signed [31:0] base,
                         longint unsigned prod);
      longint          d;
      longint unsigned mag;
      d = longint'(rd) - longint'(base);
      mag = (d < 0) ? longint'(-d) : longint'(d);
      return (mag <= min_gate) || ((mag << 16) <= prod);
    endfunction

    function edof_pkg::verdict_t settle_wheel(int w, logic signed [31:0] fresh,
                                              logic signed [31:0] rr1,
                                              logic signed [31:0] rr2,
                                              longint unsigned prod);
      logic signed [31:0] rr [2];
      logic signed [31:0] pick;
      edof_pkg::verdict_t v;
      int unsigned        n;
      rr[0] = rr1;
      rr[1] = rr2;
      if (in_gate(fresh, pos_base[w], prod)) begin
        pos_base[w] = fresh;
        reject_run[w] = '0;
        return edof_pkg::VERDICT_FRESH;
      end
      pick = pos_base[w];
      v = edof_pkg::VERDICT_HELD;
      n = (edof_pkg::RETRY_READS > 2) ? 2 : edof_pkg::RETRY_READS;
      for (int k = 0; k < n; k++) begin
        if (in_gate(rr[k & 1], pos_base[w], prod)) begin
          pick = rr[k & 1];
          v = edof_pkg::VERDICT_REREAD;
          break;
        end
      end
      // streak saturates; a limit of zero forces on every rejection
      if (reject_run[w] != 8'hff) reject_run[w] = reject_run[w] + 8'd1;
      if (reject_run[w] >= streak_limit) begin
        pick = fresh;
        v = edof_pkg::VERDICT_FORCED;
        reject_run[w] = '0;
      end
      pos_base[w] = pick;
      return v;
    endfunction

    function void take_tick(tick_t t);
      fix_t            f;
      longint unsigned prod;
      f.driving = (t.tgt_r != 0) || (t.tgt_l != 0);
      if (f.driving) begin
        prod = longint'(gate_gain) * longint'(peak(t.tgt_r, t.tgt_l));
        f.verdict_r = settle_wheel(0, t.fresh_r, t.rr1_r, t.rr2_r, prod);
        f.verdict_l = settle_wheel(1, t.fresh_l, t.rr1_l, t.rr2_l, prod);
      end else begin
        pos_base[0] = t.fresh_r;
        pos_base[1] = t.fresh_l;
        reject_run[0] = '0;
        reject_run[1] = '0;
        f.verdict_r = edof_pkg::VERDICT_FRESH;
        f.verdict_l = edof_pkg::VERDICT_FRESH;
      end
      f.pos_r = pos_base[0];
      f.pos_l = pos_base[1];
      fix_q.push_back(f);
    endfunction

    function void match_result(fix_t got);
      fix_t e;
      if (fix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result with no transaction outstanding: pos_r=%0d pos_l=%0d",
                   $realtime, got.pos_r, got.pos_l);
        return;
      end
      e = fix_q.pop_front();
      if (got.pos_r !== e.pos_r || got.pos_l !== e.pos_l || got.verdict_r !== e.verdict_r ||
          got.verdict_l !== e.verdict_l || got.driving !== e.driving) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: mismatch exp pos_r=%0d pos_l=%0d vr=%0d vl=%0d drv=%0b", $realtime,
                   e.pos_r, e.pos_l, e.verdict_r, e.verdict_l, e.driving);
          $display("%0t:          got pos_r=%0d pos_l=%0d vr=%0d vl=%0d drv=%0b", $realtime,
                   got.pos_r, got.pos_l, got.verdict_r, got.verdict_l, got.driving);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] target_right = '0;
  logic signed [15:0] target_left = '0;
  logic signed [31:0] fresh_right = '0;
  logic signed [31:0] reread1_right = '0;
  logic signed [31:0] reread2_right = '0;
  logic signed [31:0] fresh_left = '0;
  logic signed [31:0] reread1_left = '0;
  logic signed [31:0] reread2_left = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pos_right;
  logic signed [31:0] pos_left;
  logic [1:0]         verdict_right;
  logic [1:0]         verdict_left;
  logic               driving;

  position_tracker    trk;
  bit                 quiet = 1'b0;     // no idling on either side while set
  int unsigned        cycle_count = 0;

  encoder_delta_outlier_filter dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .target_right  (target_right),
    .target_left   (target_left),
    .fresh_right   (fresh_right),
    .reread1_right (reread1_right),
    .reread2_right (reread2_right),
    .fresh_left    (fresh_left),
    .reread1_left  (reread1_left),
    .reread2_left  (reread2_left),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_right     (pos_right),
    .pos_left      (pos_left),
    .verdict_right (verdict_right),
    .verdict_left  (verdict_left),
    .driving       (driving)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side. Values read right after the edge are the pre-edge ones, so a
  // transaction is taken exactly when out_valid was high and our stall was low.
  initial begin
    fix_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.pos_r     = pos_right;
        got.pos_l     = pos_left;
        got.verdict_r = edof_pkg::verdict_t'(verdict_right);
        got.verdict_l = edof_pkg::verdict_t'(verdict_left);
        got.driving   = driving;
        trk.match_result(got);
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task is entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // present one tick and hold it until the block takes it
  task automatic drive_tick(input tick_t t);
    in_valid      <= 1'b1;
    target_right  <= t.tgt_r;
    target_left   <= t.tgt_l;
    fresh_right   <= t.fresh_r;
    reread1_right <= t.rr1_r;
    reread2_right <= t.rr2_r;
    fresh_left    <= t.fresh_l;
    reread1_left  <= t.rr1_l;
    reread2_left  <= t.rr2_l;
    do @(posedge clk); while (in_stall);
    trk.take_tick(t);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle, access cycle; the register takes the value at the access edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    trk.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] mg, logic [15:0] gg, logic [7:0] sl);
    drain();
    write_reg(edof_pkg::REG_MIN_GATE, {16'h0, mg});
    write_reg(edof_pkg::REG_GATE_GAIN, {16'h0, gg});
    write_reg(edof_pkg::REG_STREAK_LIMIT, {24'h0, sl});
  endtask

  // tick whose reads are offsets from the current baselines
  function automatic tick_t aim(int tr, int tl, longint dfr, longint d1r, longint d2r,
                                longint dfl, longint d1l, longint d2l);
    tick_t t;
    t.tgt_r   = 16'(tr);
    t.tgt_l   = 16'(tl);
    t.fresh_r = trk.pos_base[0] + 32'(dfr);
    t.rr1_r   = trk.pos_base[0] + 32'(d1r);
    t.rr2_r   = trk.pos_base[0] + 32'(d2r);
    t.fresh_l = trk.pos_base[1] + 32'(dfl);
    t.rr1_l   = trk.pos_base[1] + 32'(d1l);
    t.rr2_l   = trk.pos_base[1] + 32'(d2l);
    return t;
  endfunction

  // tick with one raw value on every read field
  function automatic tick_t flat(int tr, int tl, logic signed [31:0] v);
    tick_t t;
    t.tgt_r = 16'(tr);
    t.tgt_l = 16'(tl);
    t.fresh_r = v;
    t.rr1_r = v;
    t.rr2_r = v;
    t.fresh_l = v;
    t.rr1_l = v;
    t.rr2_l = v;
    return t;
  endfunction

  // read around a baseline: inside the gate with pct_in percent, else just past the
  // edge, well past it, or anywhere at all
  function automatic logic signed [31:0] near_read(logic signed [31:0] base, longint g,
                                                   int unsigned pct_in);
    longint off;
    if ($urandom_range(0, 99) < pct_in) begin
      off = ($urandom_range(0, 7) == 0) ? g : longint'($urandom_range(0, 32'(g)));
    end else begin
      case ($urandom_range(0, 4))
        0, 1:    off = g + 1;
        2, 3:    off = g + 1 + longint'($urandom_range(0, 32'(3 * g + 16)));
        default: return $urandom;
      endcase
    end
    if ($urandom_range(0, 1) != 0) off = -off;
    return base + 32'(off);
  endfunction

  // harsh ticks never idle and never pass the fresh read, so streaks climb
  function automatic tick_t random_tick(bit harsh);
    tick_t       t;
    longint      g;
    int unsigned r;
    int unsigned pin_fresh;
    int unsigned pin_re;
    r = $urandom_range(0, 99);
    t.tgt_r = 16'($urandom);
    t.tgt_l = 16'($urandom);
    if (!harsh && r < 8) begin
      t.tgt_r = '0;
      t.tgt_l = '0;
    end else if (r < 16) begin
      if ($urandom_range(0, 1) != 0) t.tgt_r = '0;
      else t.tgt_l = '0;
    end else if (r < 24) begin
      t.tgt_r = TGT_EDGES[$urandom_range(0, 3)];
      t.tgt_l = TGT_EDGES[$urandom_range(0, 3)];
    end
    if (harsh && t.tgt_r == 0 && t.tgt_l == 0) t.tgt_r = 16'sd1;
    g = trk.span(t.tgt_r, t.tgt_l);
    pin_fresh = harsh ? 0 : 50;
    pin_re    = harsh ? 30 : 40;
    t.fresh_r = near_read(trk.pos_base[0], g, pin_fresh);
    t.rr1_r   = near_read(trk.pos_base[0], g, pin_re);
    t.rr2_r   = near_read(trk.pos_base[0], g, pin_re);
    t.fresh_l = near_read(trk.pos_base[1], g, pin_fresh);
    t.rr1_l   = near_read(trk.pos_base[1], g, pin_re);
    t.rr2_l   = near_read(trk.pos_base[1], g, pin_re);
    return t;
  endfunction

  // Hand-aimed ticks at reset registers: idle loads, each verdict, both gate edges,
  // the streak forcing a rebaseline, idle clearing streaks, rails on every field.
  task automatic run_directed();
    longint far;
    longint g;
    far = 64'sd1 <<< 31;  // 2^31 away from any baseline: outside every gate
    drive_tick(aim(0, 0, 64'sh7fffffff, 5, -5, -far, 7, -7));
    g = trk.span(-32768, 0);
    // right: first re-read on the inner edge; left: only the second re-read lands
    drive_tick(aim(-32768, 0, far, -g, far, far, far, g));
    g = trk.span(32767, -1);
    // right held; left fresh exactly on the gate
    drive_tick(aim(32767, -1, far, far, far, g, 0, 0));
    g = trk.span(100, 0);
    // right reaches the limit: fresh forced even with a good re-read
    drive_tick(aim(100, 0, far, 0, 0, g + 1, g + 1, -(g + 1)));
    g = trk.span(0, -32768);
    drive_tick(aim(0, -32768, 0, far, far, -(g + 1), -g, 0));
    // idle with a streak pending
    drive_tick(aim(0, 0, 1000, far, far, -1000, far, far));
    g = trk.span(1, 1);
    drive_tick(aim(1, 1, g + 1, g + 1, g + 1, -g, far, far));
    g = trk.span(-1, 32767);
    drive_tick(aim(-1, 32767, far, far, g + 1, far, g + 1, far));
    g = trk.span(-32768, -32768);
    drive_tick(aim(-32768, -32768, g, 0, 0, -g, 0, 0));
    drive_tick(aim(-32768, -32768, g + 1, -(g + 1), g, far, far, far));
    drive_tick(aim(16, -16, far, far, far, far, far, far));
    drive_tick(flat(32767, 32767, 32'sh80000000));
    drive_tick(flat(-32768, 1, 32'sh7fffffff));
    drive_tick(flat(0, 0, 32'shffffffff));
    drive_tick(flat(1, -1, 32'sh00000000));
    drive_tick(flat(-32768, -32768, 32'sh7fffffff));
  endtask

  // random ticks with sender gaps; pause_at >= 0 drains the block once mid-phase
  task automatic run_phase(int cnt, bit harsh, int pause_at);
    for (int i = 0; i < cnt; i++) begin
      if (i == pause_at) drain();
      drive_tick(random_tick(harsh));
      if (!quiet && $urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    trk = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase(250, 1'b0, -1);                 // reset registers
    configure(16'd0, 16'd0, 8'd1);            // zero gate: only exact repeats pass
    run_phase(150, 1'b0, -1);
    configure(16'hffff, 16'hffff, 8'd255);    // widest gate, slowest forcing
    run_phase(150, 1'b0, -1);
    configure(16'd200, 16'd40000, 8'd2);
    quiet = 1'b1;                             // back-to-back stretch
    run_phase(250, 1'b0, -1);
    quiet = 1'b0;
    configure(16'd640, 16'd13107, 8'd0);      // limit zero: every rejection forced
    run_phase(150, 1'b0, -1);
    configure(16'd16, 16'd1000, 8'd255);      // streak runs all the way to the top
    run_phase(300, 1'b1, -1);
    configure(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    run_phase(200, 1'b0, 100);
    configure(16'd0, 16'hffff, 8'd4);
    run_phase(150, 1'b0, -1);
    configure(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    run_phase(150, 1'b0, -1);

    drain();
    repeat (8) @(posedge clk);
    if (trk.mismatches == 0 && trk.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/edof_pkg.sv
rtl/edof_gate.sv
rtl/edof_wheel.sv
rtl/encoder_delta_outlier_filter.sv
verif/encoder_delta_outlier_filter_tb.sv
